// ----- hdl/bmp3_pkg.sv -----
// Shared types, constants and arithmetic helpers for the 3x3 block pixelator.
`timescale 1ns / 1ps

package bmp3_pkg;

  // Field widths.
  localparam int unsigned PIX_W = 8;
  localparam int unsigned COL_W = 12;
  localparam int unsigned SUM_W = 12;
  localparam int unsigned BLK_W = 11;
  localparam int unsigned IDX_W = 10;

  // Defaults and limits.
  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned WIDTH_RESET = 3072;
  localparam logic [IDX_W-1:0] ROW_MAX = 10'd1023;
  localparam logic [PIX_W-1:0] MEAN_MAX = 8'd255;
  localparam logic [1:0] LAST_SUB = 2'd2;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W = 2;

  // Reciprocal constants: floor(x/3) for x <= 4096, floor(x/9) for x <= 4095.
  localparam logic [11:0] DIV3_MUL = 12'd2731;
  localparam int unsigned DIV3_SHIFT = 13;
  localparam logic [12:0] DIV9_MUL = 13'd7282;
  localparam int unsigned DIV9_SHIFT = 16;

  // One pixel request handed from the front to the back.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [BLK_W-1:0] blk;
    logic [IDX_W-1:0] brow;
    logic             fresh;
    logic             emit;
  } blk_req_t;

  // Packed per-channel partial sums of one block.
  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sums_t;

  // Whole blocks in a line; a width of zero stands for 4096 pixels.
  function automatic logic [BLK_W-1:0] blocks_of(input logic [COL_W-1:0] width);
    logic [COL_W:0]  line_len;
    logic [25:0]     prod;
    line_len = (width == '0) ? 13'd4096 : {1'b0, width};
    prod = 26'(line_len) * 26'(DIV3_MUL);
    return prod[DIV3_SHIFT +: BLK_W];
  endfunction

  // Truncated mean of nine pixels, saturated to the pixel range.
  function automatic logic [PIX_W-1:0] mean_of(input logic [SUM_W-1:0] s);
    logic [24:0] prod;
    logic [8:0]  q;
    prod = 25'(s) * 25'(DIV9_MUL);
    q = prod[DIV9_SHIFT +: 9];
    return (q > 9'(MEAN_MAX)) ? MEAN_MAX : q[PIX_W-1:0];
  endfunction

endpackage

// ----- hdl/bmp3_ifs.sv -----
// Valid/ready channel interfaces for pixel requests and block results.
`timescale 1ns / 1ps

interface bmp3_pix_if;
  import bmp3_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic             frame_start;

  modport source(output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink(input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface bmp3_res_if;
  import bmp3_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] mean_red;
  logic [PIX_W-1:0] mean_green;
  logic [PIX_W-1:0] mean_blue;
  logic [IDX_W-1:0] block_column;
  logic [IDX_W-1:0] block_row;

  modport source(output valid, mean_red, mean_green, mean_blue, block_column, block_row,
                 input ready);
  modport sink(input valid, mean_red, mean_green, mean_blue, block_column, block_row,
               output ready);
endinterface

// ----- hdl/bmp3_front.sv -----
// Front end: raster position tracking and classification of each pixel.
`timescale 1ns / 1ps

module bmp3_front #(
  parameter int unsigned MAX_BLOCKS = bmp3_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  bmp3_pix_if.sink                   pix,
  input  logic                       cfg_we,
  input  logic [bmp3_pkg::COL_W-1:0] cfg_data,
  input  logic                       q_full,
  output logic                       q_push,
  output bmp3_pkg::blk_req_t         q_req
);
  import bmp3_pkg::*;

  localparam int unsigned RST_NB_I =
    (WIDTH_RESET / 3 > MAX_BLOCKS) ? MAX_BLOCKS : WIDTH_RESET / 3;
  localparam logic [BLK_W-1:0] RST_NB = BLK_W'(RST_NB_I);
  localparam logic [COL_W-1:0] RST_LAST = COL_W'(WIDTH_RESET - 1);

  logic [COL_W-1:0] last_col;
  logic [BLK_W-1:0] nblocks;
  logic [BLK_W-1:0] cfg_nb_raw;
  logic [BLK_W-1:0] cfg_nb;

  logic [COL_W-1:0] col, col_next;
  logic [1:0]       col_phase, col_phase_next;
  logic [BLK_W-1:0] blk, blk_next;
  logic [1:0]       rib, rib_next;
  logic [IDX_W-1:0] brow, brow_next;

  logic [COL_W-1:0] eff_col;
  logic [1:0]       eff_phase;
  logic [BLK_W-1:0] eff_blk;
  logic [1:0]       eff_rib;
  logic [IDX_W-1:0] eff_brow;
  logic             accept;

  // Block count for a newly written width, capped to the sum line depth.
  always_comb begin
    cfg_nb_raw = blocks_of(cfg_data);
    cfg_nb = (32'(cfg_nb_raw) > MAX_BLOCKS) ? BLK_W'(MAX_BLOCKS) : cfg_nb_raw;
  end

  // Width register, kept as the last column index and the block count.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= RST_LAST;
      nblocks <= RST_NB;
    end else if (cfg_we) begin
      last_col <= cfg_data - 1'b1;
      nblocks <= cfg_nb;
    end
  end

  assign pix.ready = !q_full;
  assign accept = pix.valid && pix.ready;

  // Position as seen by this pixel; a frame start clears it first.
  always_comb begin
    eff_col = pix.frame_start ? '0 : col;
    eff_phase = pix.frame_start ? '0 : col_phase;
    eff_blk = pix.frame_start ? '0 : blk;
    eff_rib = pix.frame_start ? '0 : rib;
    eff_brow = pix.frame_start ? '0 : brow;
  end

  // Classify the pixel and hand it on only if its block column lies within the whole blocks of the line.
  always_comb begin
    q_push = accept && (eff_blk < nblocks);
    q_req.red = pix.red_in;
    q_req.green = pix.green_in;
    q_req.blue = pix.blue_in;
    q_req.blk = eff_blk;
    q_req.brow = eff_brow;
    q_req.fresh = (eff_rib == '0) && (eff_phase == '0);
    q_req.emit = (eff_rib == LAST_SUB) && (eff_phase == LAST_SUB);
  end

  // Advance the raster position.
  always_comb begin
    col_next = eff_col;
    col_phase_next = eff_phase;
    blk_next = eff_blk;
    rib_next = eff_rib;
    brow_next = eff_brow;
    if (eff_col == last_col) begin
      col_next = '0;
      col_phase_next = '0;
      blk_next = '0;
      if (eff_rib >= LAST_SUB) begin
        rib_next = '0;
        if (eff_brow != ROW_MAX) begin
          brow_next = eff_brow + 1'b1;
        end
      end else begin
        rib_next = eff_rib + 1'b1;
      end
    end else begin
      col_next = eff_col + 1'b1;
      if (eff_phase == LAST_SUB) begin
        col_phase_next = '0;
        blk_next = eff_blk + 1'b1;
      end else begin
        col_phase_next = eff_phase + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      col_phase <= '0;
      blk <= '0;
      rib <= '0;
      brow <= '0;
    end else if (accept) begin
      col <= col_next;
      col_phase <= col_phase_next;
      blk <= blk_next;
      rib <= rib_next;
      brow <= brow_next;
    end
  end

  // A frame start always begins a fresh block at the top left.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && pix.frame_start |-> q_req.fresh && !q_req.emit && q_req.blk == '0)
    else $error("frame start did not restart the block position");

  // Apart from a frame start, the block row only moves when a line ends.
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    accept && !pix.frame_start && col != last_col |=> brow == $past(brow))
    else $error("block row changed in mid line");

  // The column phase and the row-in-block counter stay within their range.
  a_phase: assert property (@(posedge clk) disable iff (rst)
    col_phase != 2'd3 && rib != 2'd3)
    else $error("sub-block counter left its range");

endmodule

// ----- hdl/bmp3_queue.sv -----
// Short request queue between the front end and the accumulation back end.
`timescale 1ns / 1ps

module bmp3_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bmp3_pkg::blk_req_t din,
  output logic               full,
  input  logic               pop,
  output bmp3_pkg::blk_req_t dout,
  output logic               empty
);
  import bmp3_pkg::*;

  blk_req_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   cnt;

  assign full = (cnt == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (cnt == '0);
  assign dout = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> cnt == (PTR_W + 1)'(QUEUE_DEPTH) && !push)
    else $error("request written into a full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("request taken from an empty queue");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    push && !pop && !full |=> cnt == $past(cnt) + 1'b1)
    else $error("fill count lost a request");

endmodule

// ----- hdl/bmp3_back.sv -----
// Back end: sum line read-modify-write, mean computation and result register.
`timescale 1ns / 1ps

module bmp3_back #(
  parameter int unsigned MAX_BLOCKS = bmp3_pkg::MAX_BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  bmp3_pkg::blk_req_t q_req,
  output logic               q_pop,
  bmp3_res_if.source         res
);
  import bmp3_pkg::*;

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  sums_t    sum_line [MAX_BLOCKS];
  sums_t    rd_data;
  sums_t    fwd_data;
  logic     fwd_hit;

  logic     s1_valid;
  blk_req_t s1_req;
  sums_t    s1_old;
  sums_t    s1_sum;
  logic     s1_adv;

  logic             s2_valid;
  sums_t            s2_sum;
  logic [IDX_W-1:0] s2_col;
  logic [IDX_W-1:0] s2_row;
  logic             s2_ready;
  logic             out_load;

  // Handshake between the stages.
  always_comb begin
    out_load = !res.valid || res.ready;
    s2_ready = !s2_valid || out_load;
    s1_adv = s1_valid && (!s1_req.emit || s2_ready);
    q_pop = !q_empty && (!s1_valid || s1_adv);
  end

  // Add the pixel to the block's partial sum; the previous write is bypassed.
  always_comb begin
    if (s1_req.fresh) begin
      s1_old = '0;
    end else if (fwd_hit) begin
      s1_old = fwd_data;
    end else begin
      s1_old = rd_data;
    end
    s1_sum.red = s1_old.red + SUM_W'(s1_req.red);
    s1_sum.green = s1_old.green + SUM_W'(s1_req.green);
    s1_sum.blue = s1_old.blue + SUM_W'(s1_req.blue);
  end

  // Sum line memory with a registered read and a one-deep bypass.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      sum_line[AW'(s1_req.blk)] <= s1_sum;
    end
    if (q_pop) begin
      rd_data <= sum_line[AW'(q_req.blk)];
      fwd_hit <= s1_adv && (s1_req.blk == q_req.blk);
      fwd_data <= s1_sum;
      s1_req <= q_req;
    end
  end

  // Stage one occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage two holds finished block sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_adv && s1_req.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_adv && s1_req.emit) begin
      s2_sum <= s1_sum;
      s2_col <= s1_req.blk[IDX_W-1:0];
      s2_row <= s1_req.brow;
    end
  end

  // Output register with the means.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s2_valid) begin
      res.mean_red <= mean_of(s2_sum.red);
      res.mean_green <= mean_of(s2_sum.green);
      res.mean_blue <= mean_of(s2_sum.blue);
      res.block_column <= s2_col;
      res.block_row <= s2_row;
    end
  end

  a_pop_lands: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> s1_valid)
    else $error("popped request did not reach stage one");

  a_emit_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_req.emit && !s2_ready |=> s1_valid && s1_req.emit)
    else $error("finished block dropped while stalled");

  a_s2_held: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_load |=> s2_valid && $stable(s2_sum))
    else $error("block sums changed while stalled");

  a_s2_out: assert property (@(posedge clk) disable iff (rst)
    s2_valid && out_load |=> res.valid)
    else $error("block sums did not reach the output");

endmodule

// ----- hdl/block_mean_pixelate_3x3.sv -----
// Top level of the 3x3 block-mean pixelator.
`timescale 1ns / 1ps

// Usage:
// Pixels arrive on the pix channel in raster order, one request per pixel,
// with frame_start set on the first pixel of each frame. The image width is
// written through cfg_we/cfg_data while the block is idle.
// Each full 3x3 block gives one request on the res channel, issued after the
// ninth pixel of the block (bottom right) is taken: the truncated mean of each
// channel and the block's column and row. Partial blocks at the right edge and
// at the bottom are never reported.
// Each result passes stage one, stage two and the output register. Throughput:
// one pixel per cycle while the queue has room. The sum line memory does one
// read and one write per cycle, and a bypass covers consecutive pixels of the
// same block. A four-entry request queue sits between the position tracker and
// the accumulator, and a registered output stage holds a finished result.
// Reset clears all counters, the queue and the pipeline; the width returns to
// 3072 pixels. The sum line needs no clearing, since every block starts fresh.
// When the receiver stalls, results wait in the output and stage registers;
// once the queue fills, pix.ready drops until the receiver takes results.

module block_mean_pixelate_3x3 #(
  parameter int unsigned MAX_BLOCKS_PER_LINE = bmp3_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  bmp3_pix_if.sink                   pix,
  bmp3_res_if.source                 res,
  input  logic                       cfg_we,
  input  logic [bmp3_pkg::COL_W-1:0] cfg_data
);
  import bmp3_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  blk_req_t q_in;
  blk_req_t q_out;

  // Position tracking and classification.
  bmp3_front #(.MAX_BLOCKS(MAX_BLOCKS_PER_LINE)) u_front (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_req    (q_in)
  );

  // Decoupling queue.
  bmp3_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  // Accumulation and result output.
  bmp3_back #(.MAX_BLOCKS(MAX_BLOCKS_PER_LINE)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_req   (q_out),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule
